@@ src/lphm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// shared constants, codes and types of the linear probe hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

    // default number of slots, a power of two
    localparam int TABLE_ENTRIES_DEF = 1024;

    // key and value width
    localparam int DATA_W = 64;

    // multiplicative hash constant
    localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISS     = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_ZERO_KEY = 2'd3
    } t_status;

    // write enables of the slot memories
    typedef struct packed {
        logic key_en;
        logic val_en;
    } t_wr_ctl;

endpackage

@@ src/lphm_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_hash
// home slot unit: 64-bit multiply by partial products on one shared 32x32
// multiplier, high half folded into the low half, low bits kept
// ----------------------------------------------------------------------------
module lphm_hash #(
    parameter int ADDR_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lphm_pkg::DATA_W-1:0]  i_key,
    output logic                         o_done,
    output logic [ADDR_W-1:0]            o_slot
);

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_LO,
        STEP_CROSS_H,
        STEP_CROSS_L
    } t_step;

    t_step                        r_step;
    logic                         r_done;
    logic [lphm_pkg::DATA_W-1:0]  r_key;
    logic [ADDR_W-1:0]            r_lo;
    logic [ADDR_W-1:0]            r_hi;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // only the low ADDR_W bits of both halves matter after the fold
    always_comb begin
        case (r_step)
            STEP_LO: begin
                mul_a = r_key[31:0];
                mul_b = lphm_pkg::HASH_MULT[31:0];
            end
            STEP_CROSS_H: begin
                mul_a = r_key[63:32];
                mul_b = lphm_pkg::HASH_MULT[31:0];
            end
            default: begin
                mul_a = r_key[31:0];
                mul_b = lphm_pkg::HASH_MULT[63:32];
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_step)
                STEP_IDLE: begin
                    if (i_start) begin
                        r_key  <= i_key;
                        r_step <= STEP_LO;
                    end
                end
                STEP_LO: begin
                    r_lo   <= prod[ADDR_W-1:0];
                    r_hi   <= prod[32+ADDR_W-1:32];
                    r_step <= STEP_CROSS_H;
                end
                STEP_CROSS_H: begin
                    r_hi   <= r_hi + prod[ADDR_W-1:0];
                    r_step <= STEP_CROSS_L;
                end
                STEP_CROSS_L: begin
                    r_hi   <= r_hi + prod[ADDR_W-1:0];
                    r_done <= 1'b1;
                    r_step <= STEP_IDLE;
                end
                default: begin
                    r_step <= STEP_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_lo ^ r_hi;

endmodule

@@ src/lphm_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_mem
// key and value slot memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module lphm_mem #(
    parameter int ADDR_W = 10
) (
    input  logic                         i_clk,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [lphm_pkg::DATA_W-1:0]  o_rd_key,
    output logic [lphm_pkg::DATA_W-1:0]  o_rd_value,
    input  lphm_pkg::t_wr_ctl            i_wr_ctl,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [lphm_pkg::DATA_W-1:0]  i_wr_key,
    input  logic [lphm_pkg::DATA_W-1:0]  i_wr_value
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [lphm_pkg::DATA_W-1:0] r_key_mem [DEPTH];
    logic [lphm_pkg::DATA_W-1:0] r_val_mem [DEPTH];
    logic [lphm_pkg::DATA_W-1:0] r_rd_key;
    logic [lphm_pkg::DATA_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.key_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.val_en) begin
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
        r_rd_value <= r_val_mem[i_rd_addr];
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule

@@ src/linear_probe_hash_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// open addressing table of 64-bit keys and values with linear probing
// ----------------------------------------------------------------------------
// usage
//   slave beat: s_axis_tuser[0] opcode (0 lookup, 1 store), tdata key/value.
//   master beat: m_axis_tdata read_value, m_axis_tuser status
//   (0 hit or stored, 1 miss, 2 full refused, 3 zero key refused).
//   one result beat per request beat, in order. one request is in work at
//   a time; the next beat is taken as soon as the result sits in the output
//   register, even if the receiver has not taken it yet.
// sequence
//   requests that need no table access (zero key, zero store value, lookup
//   in an empty table) go from the accept cycle straight to posting the
//   result.
//   others pass the accept cycle, the steps STEP_LO, STEP_CROSS_H and
//   STEP_CROSS_L on the shared 32x32 multiplier for the home slot, the issue
//   of the first read, then one probed slot per cycle (the next slot is
//   read while the current one is checked), and the posting of the result.
// reset
//   after reset the key memory is swept to empty, one slot a cycle, over
//   every slot; s_axis_tready stays low meanwhile. the value
//   memory is not cleared; a value is only read where its key matched.
// stall
//   a stalled receiver holds the result; a finished request then waits for
//   the output register to free before the next beat is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
    parameter int TABLE_ENTRIES = lphm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] key, [127:64] value
    input  logic [0:0]   s_axis_tuser,   // [0] opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [63:0] read_value
    output logic [1:0]   m_axis_tuser    // [1:0] status
);

    localparam int DW     = lphm_pkg::DATA_W;
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    // entry count reaches at most half the table
    localparam logic [ADDR_W-1:0] CNT_HALF = ADDR_W'(TABLE_ENTRIES / 2);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [ADDR_W-1:0]     r_count;
    logic [ADDR_W-1:0]     r_slot;
    logic [ADDR_W-1:0]     r_n;
    lphm_pkg::t_opcode     r_op;
    logic [DW-1:0]         r_key;
    logic [DW-1:0]         r_value;
    logic [DW-1:0]         r_res_value;
    lphm_pkg::t_status     r_res_status;
    logic                  r_out_valid;
    logic [DW-1:0]         r_out_value;
    lphm_pkg::t_status     r_out_status;

    // request fields
    lphm_pkg::t_opcode in_op;
    logic [DW-1:0]     in_key;
    logic [DW-1:0]     in_value;
    logic              accept;
    logic              in_short;   // answered without touching the table
    lphm_pkg::t_status in_status;

    // hash unit
    logic              hash_start;
    logic              hash_done;
    logic [ADDR_W-1:0] hash_slot;

    // memory side
    logic [ADDR_W-1:0] rd_addr;
    logic [DW-1:0]     rd_key;
    logic [DW-1:0]     rd_value;
    lphm_pkg::t_wr_ctl wr_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [DW-1:0]     wr_key;

    // probe decision
    logic hit;
    logic empty;
    logic last_probe;
    logic full;
    logic is_store;

    assign in_op    = lphm_pkg::t_opcode'(s_axis_tuser[0]);
    assign in_key   = s_axis_tdata[DW-1:0];
    assign in_value = s_axis_tdata[2*DW-1:DW];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // the special cases resolved at the input
    always_comb begin
        in_short  = 1'b0;
        in_status = lphm_pkg::STATUS_OK;
        if (in_op == lphm_pkg::OP_LOOKUP) begin
            in_status = lphm_pkg::STATUS_MISS;
            in_short  = (in_key == '0) || (r_count == '0);
        end else if (in_key == '0) begin
            in_status = lphm_pkg::STATUS_ZERO_KEY;
            in_short  = 1'b1;
        end else if (in_value == '0) begin
            in_status = lphm_pkg::STATUS_OK;
            in_short  = 1'b1;
        end
    end

    assign hash_start = accept && !in_short;

    lphm_hash #(
        .ADDR_W (ADDR_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (in_key),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    // key of the current slot is valid in ST_CHECK
    assign hit        = (rd_key == r_key);
    assign empty      = (rd_key == '0);
    assign last_probe = (r_n == '1);
    assign full       = (r_count >= CNT_HALF);
    assign is_store   = (r_op == lphm_pkg::OP_STORE);

    // read the home slot when the hash lands, then always one slot ahead;
    // the address wraps through the width of the slot index
    assign rd_addr = (r_state == ST_HASH) ? hash_slot : r_slot + ADDR_W'(1);

    // the only write in a request happens on its last probe cycle, and the
    // next request reads no earlier than its hash has finished, so reads and
    // writes to the same slot never overlap
    always_comb begin
        wr_ctl.key_en = 1'b0;
        wr_ctl.val_en = 1'b0;
        if (r_state == ST_CLEAR) begin
            wr_ctl.key_en = 1'b1;
        end else if (r_state == ST_CHECK && is_store) begin
            if (hit) begin
                wr_ctl.val_en = 1'b1;
            end else if (empty && !full) begin
                wr_ctl.key_en = 1'b1;
                wr_ctl.val_en = 1'b1;
            end
        end
    end

    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_slot;
    assign wr_key  = (r_state == ST_CLEAR) ? '0 : r_key;

    lphm_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value),
        .i_wr_ctl   (wr_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_value (r_value)
    );

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in ST_FINISH the output register is reloaded instead
            if (r_out_valid && m_axis_tready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_op         <= in_op;
                        r_key        <= in_key;
                        r_value      <= in_value;
                        r_res_value  <= '0;
                        r_res_status <= in_status;
                        r_state      <= in_short ? ST_FINISH : ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (hash_done) begin
                        r_slot  <= hash_slot;
                        r_n     <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (hit) begin
                        r_res_value  <= is_store ? '0 : rd_value;
                        r_res_status <= lphm_pkg::STATUS_OK;
                        r_state      <= ST_FINISH;
                    end else if (empty) begin
                        if (!is_store) begin
                            r_res_status <= lphm_pkg::STATUS_MISS;
                        end else if (full) begin
                            r_res_status <= lphm_pkg::STATUS_FULL;
                        end else begin
                            r_res_status <= lphm_pkg::STATUS_OK;
                            r_count      <= r_count + ADDR_W'(1);
                        end
                        r_state <= ST_FINISH;
                    end else if (last_probe) begin
                        // every slot seen without a match or an empty slot
                        r_res_status <= is_store ? lphm_pkg::STATUS_FULL
                                                 : lphm_pkg::STATUS_MISS;
                        r_state      <= ST_FINISH;
                    end else begin
                        r_slot <= r_slot + ADDR_W'(1);
                        r_n    <= r_n + ADDR_W'(1);
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // entries never pass half the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_HALF)
        else $error("entry count above half the table");

    // the entry count moves only on a store that finished its probe
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        ($past(r_state) == ST_CHECK && $past(r_op) == lphm_pkg::OP_STORE))
        else $error("entry count changed outside a store");

    // the hash unit only reports back to a request waiting on it
    a_hash_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == ST_HASH))
        else $error("hash result with no request waiting");

    // one request in work at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in work");

endmodule

@@ tb/sv/linear_probe_hash_map_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_tb
// self-checking bench for the linear probe hash map: a mirror table predicts
// every result beat; directed corner cases first, then random lookups and
// stores that grow the table to half load and push it into refusal
// ----------------------------------------------------------------------------
module linear_probe_hash_map_tb;

    // table size of the instance and slot index width
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);

    // multiplicative hash used to find the home slot
    localparam logic [63:0] HOME_MULT = 64'hff51afd7ed558ccd;

    // one result beat: read value and status
    typedef struct packed {
        logic [63:0]       read_value;
        lphm_pkg::t_status status;
    } t_map_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;     // [63:0] key, [127:64] value
    logic [0:0]   s_axis_tuser = '0;     // [0] opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;          // [63:0] read_value
    logic [1:0]   m_axis_tuser;          // [1:0] status

    // mirror of the slot memories and the occupancy counter
    logic [63:0] key_mirror [SLOTS];
    logic [63:0] val_mirror [SLOTS];
    int          occupancy;

    // keys that claimed a slot, picked again for hits and updates
    logic [63:0] stored_keys [$];

    // predicted result beats, oldest first
    t_map_result pending_results [$];

    // idle and stall rates in percent of cycles
    int send_idle_pct  = 37;
    int recv_stall_pct = 76;

    int fail_count = 0;

    linear_probe_hash_map #(
        .TABLE_ENTRIES(SLOTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // home slot: product xor its upper half, low bits kept
    function automatic int home_slot_of(logic [63:0] key);
        logic [63:0] h;
        h = key * HOME_MULT;
        h = h ^ (h >> 32);
        return int'(h[SLOT_W-1:0]);
    endfunction

    // apply one request to the mirror and return the beat it must produce
    function automatic t_map_result hash_map_predict(lphm_pkg::t_opcode op,
                                                     logic [63:0] key,
                                                     logic [63:0] val);
        t_map_result res;
        int          s;
        bit          found;
        bit          have_empty;
        int          empty_at;
        res.read_value = '0;
        res.status     = lphm_pkg::STATUS_OK;
        found          = 1'b0;
        have_empty     = 1'b0;
        empty_at       = 0;
        if (op == lphm_pkg::OP_LOOKUP) begin
            res.status = lphm_pkg::STATUS_MISS;
            if (key != '0 && occupancy != 0) begin
                s = home_slot_of(key);
                for (int n = 0; n < SLOTS; n++) begin
                    if (key_mirror[s] == key) begin
                        res.read_value = val_mirror[s];
                        res.status     = lphm_pkg::STATUS_OK;
                        break;
                    end
                    if (key_mirror[s] == '0) break;
                    s = (s + 1) % SLOTS;
                end
            end
        end else if (key == '0) begin
            // zero key is refused before anything else
            res.status = lphm_pkg::STATUS_ZERO_KEY;
        end else if (val != '0) begin
            // a zero value falls through as an ignored store
            s = home_slot_of(key);
            for (int n = 0; n < SLOTS; n++) begin
                if (key_mirror[s] == key) begin
                    val_mirror[s] = val;
                    found         = 1'b1;
                    break;
                end
                if (key_mirror[s] == '0) begin
                    have_empty = 1'b1;
                    empty_at   = s;
                    break;
                end
                s = (s + 1) % SLOTS;
            end
            if (!found) begin
                if (2 * occupancy >= SLOTS || !have_empty) begin
                    res.status = lphm_pkg::STATUS_FULL;
                end else begin
                    key_mirror[empty_at] = key;
                    val_mirror[empty_at] = val;
                    occupancy++;
                    stored_keys.push_back(key);
                end
            end
        end
        return res;
    endfunction

    // drive one request beat, predict it once it is taken
    task automatic send_request(lphm_pkg::t_opcode op, logic [63:0] key,
                                logic [63:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(hash_map_predict(op, key, val));
    endtask

    // hold the sender off until every predicted beat has come back
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // random key whose home slot is the given one
    function automatic logic [63:0] key_homed_at(int slot);
        logic [63:0] k;
        do k = {$urandom, $urandom}; while (k == '0 || home_slot_of(k) != slot);
        return k;
    endfunction

    // a key already in the table, or a fresh one while it is empty
    function automatic logic [63:0] pick_known_key();
        if (stored_keys.size() == 0) return {$urandom, $urandom} | 64'd1;
        return stored_keys[$urandom_range(stored_keys.size() - 1)];
    endfunction

    // mostly well formed traffic on known keys, with fresh keys and noise
    task automatic random_traffic(int n_items, int fresh_pct);
        int          r;
        logic [63:0] v;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            v = {$urandom, $urandom};
            if (v == '0) v = 64'd1;
            if (r < fresh_pct) begin
                send_request(lphm_pkg::OP_STORE, {$urandom, $urandom} | 64'd1, v);
            end else if (r < fresh_pct + (90 - fresh_pct) / 2) begin
                // update of a known key, now and then with a zero value
                if ($urandom_range(31) == 0) v = '0;
                send_request(lphm_pkg::OP_STORE, pick_known_key(), v);
            end else if (r < 90) begin
                send_request(lphm_pkg::OP_LOOKUP, pick_known_key(),
                             {$urandom, $urandom});
            end else if (r < 95) begin
                // lookup of a key that is most likely absent
                send_request(lphm_pkg::OP_LOOKUP, {$urandom, $urandom},
                             {$urandom, $urandom});
            end else if (r < 98) begin
                // zero key with either opcode
                send_request(lphm_pkg::t_opcode'($urandom_range(1)), '0,
                             $urandom_range(1) ? v : 64'd0);
            end else begin
                send_request(lphm_pkg::OP_STORE, {$urandom, $urandom}, '0);
            end
        end
    endtask

    // corner cases: zero key, zero value, extremes, wrap of the probe
    task automatic test_directed();
        logic [63:0] wrap_key [4];
        logic [63:0] home0_key;
        for (int i = 0; i < 4; i++) wrap_key[i] = key_homed_at(SLOTS - 1);
        home0_key = key_homed_at(0);
        send_request(lphm_pkg::OP_LOOKUP, '0, '0);
        send_request(lphm_pkg::OP_LOOKUP, {$urandom, $urandom}, '1);
        send_request(lphm_pkg::OP_STORE, '0, '1);
        send_request(lphm_pkg::OP_STORE, '0, '0);
        send_request(lphm_pkg::OP_STORE, '1, '0);
        send_request(lphm_pkg::OP_LOOKUP, '1, '0);
        send_request(lphm_pkg::OP_STORE, '1, '1);
        send_request(lphm_pkg::OP_LOOKUP, '1, '0);
        send_request(lphm_pkg::OP_STORE, '1, 64'd1);
        send_request(lphm_pkg::OP_STORE, '1, '0);
        send_request(lphm_pkg::OP_LOOKUP, '1, '1);
        send_request(lphm_pkg::OP_STORE, 64'd1, 64'h8000_0000_0000_0000);
        send_request(lphm_pkg::OP_LOOKUP, 64'd1, '0);
        send_request(lphm_pkg::OP_LOOKUP, '0, '1);
        // three keys on the last slot spill over to slots 0 and 1
        for (int i = 0; i < 3; i++) begin
            send_request(lphm_pkg::OP_STORE, wrap_key[i], {$urandom, $urandom});
        end
        send_request(lphm_pkg::OP_LOOKUP, wrap_key[2], '0);
        send_request(lphm_pkg::OP_LOOKUP, wrap_key[3], '0);
        // a key homed at slot 0 lands behind the spilled cluster
        send_request(lphm_pkg::OP_STORE, home0_key, {$urandom, $urandom});
        send_request(lphm_pkg::OP_LOOKUP, home0_key, '0);
        send_request(lphm_pkg::OP_LOOKUP, wrap_key[0], '1);
        send_request(lphm_pkg::OP_STORE, wrap_key[1], '1);
        send_request(lphm_pkg::OP_LOOKUP, wrap_key[1], '0);
    endtask

    // table at low load, mostly hits and updates
    task automatic test_random_mix();
        random_traffic(400, 20);
    endtask

    // grow to half load, then keep offering new keys
    task automatic test_fill_to_full();
        while (2 * occupancy < SLOTS) random_traffic(1, 75);
        random_traffic(100, 50);
    endtask

    // at half load new keys are refused while updates still go through
    task automatic test_full_table();
        random_traffic(400, 20);
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_map_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: read_value %h status %0d",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata !== exp_res.read_value) begin
                    $error("read_value mismatch: expected %h, actual %h",
                           exp_res.read_value, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        foreach (key_mirror[i]) begin
            key_mirror[i] = '0;
            val_mirror[i] = '0;
        end
        occupancy = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slow sender, stalling receiver
        send_idle_pct  = 37;
        recv_stall_pct = 76;
        test_directed();
        test_random_mix();
        pause_until_drained();

        // roles swapped
        send_idle_pct  = 76;
        recv_stall_pct = 37;
        test_fill_to_full();

        // full rate both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_full_table();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // room for any stray beat to show up
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
